// ===== hw/rtl/bpc_pkg.sv =====
// Shared types and constants for the barometric pressure compensation core.
// No dependencies; the core, bpc_div and bpc_tail refer to this package by scoped names.
package bpc_pkg;

	localparam int unsigned DataW   = 32;
	localparam int unsigned CfgIdxW = 8;

	// Sideband widths carried through the temperature and pressure dividers.
	localparam int unsigned TdivSideW = 55;
	localparam int unsigned PdivSideW = 35;

	localparam logic [31:0] OffsetB6 = 32'd4000;
	localparam logic [31:0] BiasB4   = 32'd32768;
	localparam logic [31:0] ScaleB7  = 32'd50000;
	localparam logic [31:0] RoundT   = 32'd8;
	localparam logic [31:0] ParamMg  = 32'd3038;
	localparam logic [31:0] ParamMh  = 32'hFFFF_E343; // -7357
	localparam logic [31:0] ParamMi  = 32'd3791;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_TDIV = 2'd1,
		ST_PDIV = 2'd2
	} status_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_AC1   = 8'd0,
		REG_AC2   = 8'd1,
		REG_AC3   = 8'd2,
		REG_AC4   = 8'd3,
		REG_AC5   = 8'd4,
		REG_AC6   = 8'd5,
		REG_B1_B2 = 8'd6,
		REG_MC_MD = 8'd7
	} reg_idx_t;

	// Control that travels with the pressure quotient into the tail.
	typedef struct packed {
		logic    valid;
		status_t status;
		logic    big;
	} tail_ctl_t;

	function automatic logic [31:0] sx16(input logic [15:0] v);
		sx16 = {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] asr(input logic [31:0] v, input int unsigned n);
		asr = 32'($signed(v) >>> n);
	endfunction

endpackage

// ===== hw/rtl/bpc_smp_if.sv =====
// Request channel carrying one raw sample to the compensation core.
// Depends on nothing.
interface bpc_smp_if;
	logic        valid;
	logic        ready;
	logic [15:0] raw_temp;
	logic [18:0] raw_press;
	logic [1:0]  oversampling;
	modport source (output valid, raw_temp, raw_press, oversampling, input ready);
	modport sink (input valid, raw_temp, raw_press, oversampling, output ready);
endinterface

// ===== hw/rtl/bpc_res_if.sv =====
// Request channel carrying one compensated result out of the core.
// Depends on nothing.
interface bpc_res_if;
	logic        valid;
	logic        ready;
	logic [31:0] temp_tenths;
	logic [31:0] press_pa;
	logic [1:0]  status;
	modport source (output valid, temp_tenths, press_pa, status, input ready);
	modport sink (input valid, temp_tenths, press_pa, status, output ready);
endinterface

// ===== hw/rtl/bpc_cfg_if.sv =====
// Register write channel for the calibration coefficients.
// Depends on nothing.
interface bpc_cfg_if;
	logic        valid;
	logic        ready;
	logic [7:0]  reg_index;
	logic [31:0] wdata;
	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

// ===== hw/rtl/barometric_pressure_compensation_core.sv =====
// Top level of the barometric pressure compensation core.
// Depends on bpc_pkg, the three channel interfaces, bpc_div and bpc_tail.
//
// The core applies the classic integer compensation of a factory-calibrated
// barometer to a stream of raw samples: each request on smp carries a raw
// temperature word, an aligned raw pressure word and the oversampling setting,
// and yields exactly one request on res with temperature in 0.1 degC, pressure
// in pascal and a status (zero divisor in the temperature or pressure path).
// The datapath is one pipeline of 76 register stages: twelve arithmetic
// stages and two 32-stage dividers that retire one quotient bit per stage.
// A new sample is taken every clock cycle unless the pipeline halts. All
// stages advance together and halt as one whenever a finished result waits
// in the output register and the consumer is not ready, so nothing is
// dropped or repeated. Coefficients are written through cfg (always ready)
// and must only change while the pipeline is empty; writes to indexes
// beyond the eighth register are ignored.
module barometric_pressure_compensation_core (
	input  logic         clk,
	input  logic         arst_n,
	bpc_smp_if.sink      smp,
	bpc_res_if.source    res,
	bpc_cfg_if.sink      cfg
);
	// Calibration registers.
	logic [15:0] ac1_q, ac2_q, ac3_q, ac4_q, ac5_q, ac6_q;
	logic [31:0] b1b2_q, mcmd_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac1_q  <= '0;
			ac2_q  <= '0;
			ac3_q  <= '0;
			ac4_q  <= '0;
			ac5_q  <= '0;
			ac6_q  <= '0;
			b1b2_q <= '0;
			mcmd_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				bpc_pkg::REG_AC1:   ac1_q  <= cfg.wdata[15:0];
				bpc_pkg::REG_AC2:   ac2_q  <= cfg.wdata[15:0];
				bpc_pkg::REG_AC3:   ac3_q  <= cfg.wdata[15:0];
				bpc_pkg::REG_AC4:   ac4_q  <= cfg.wdata[15:0];
				bpc_pkg::REG_AC5:   ac5_q  <= cfg.wdata[15:0];
				bpc_pkg::REG_AC6:   ac6_q  <= cfg.wdata[15:0];
				bpc_pkg::REG_B1_B2: b1b2_q <= cfg.wdata;
				bpc_pkg::REG_MC_MD: mcmd_q <= cfg.wdata;
				default: ;
			endcase
		end
	end

	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	assign ac1 = bpc_pkg::sx16(ac1_q);
	assign ac2 = bpc_pkg::sx16(ac2_q);
	assign ac3 = bpc_pkg::sx16(ac3_q);
	assign ac4 = {16'd0, ac4_q};
	assign ac5 = {16'd0, ac5_q};
	assign ac6 = {16'd0, ac6_q};
	assign b1  = bpc_pkg::sx16(b1b2_q[31:16]);
	assign b2  = bpc_pkg::sx16(b1b2_q[15:0]);
	assign mc  = bpc_pkg::sx16(mcmd_q[31:16]);
	assign md  = bpc_pkg::sx16(mcmd_q[15:0]);

	// One enable for the whole pipeline: it moves unless a result is held.
	logic en;
	assign en        = !res.valid || res.ready;
	assign smp.ready = en;

	// Stage 1: temperature slope product.
	logic        vld_s1;
	logic [31:0] prod_s1;
	logic [18:0] up_s1;
	logic [1:0]  oss_s1;

	// Stage 2: x1, zero-divisor flag, result sign and operand magnitudes of the temperature division.
	logic        vld_s2, zero_s2, neg_s2;
	logic [31:0] x1_s2, ma_s2, mb_s2;
	logic [18:0] up_s2;
	logic [1:0]  oss_s2;
	logic [31:0] x1_c, den_c, num_c;

	assign x1_c  = bpc_pkg::asr(prod_s1, 15);
	assign den_c = x1_c + md;
	assign num_c = {mc[20:0], 11'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= smp.valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= ({16'd0, smp.raw_temp} - ac6) * ac5;
			up_s1   <= smp.raw_press;
			oss_s1  <= smp.oversampling;

			x1_s2   <= x1_c;
			zero_s2 <= (den_c == '0);
			neg_s2  <= num_c[31] ^ den_c[31];
			ma_s2   <= num_c[31] ? -num_c : num_c;
			mb_s2   <= den_c[31] ? -den_c : den_c;
			up_s2   <= up_s1;
			oss_s2  <= oss_s1;
		end
	end

	// Temperature division.
	logic                            d1_valid;
	logic [31:0]                     d1_q;
	logic [bpc_pkg::TdivSideW-1:0]   d1_side_in, d1_side;
	assign d1_side_in = {x1_s2, neg_s2, zero_s2, up_s2, oss_s2};

	bpc_div #(.SIDE_W(bpc_pkg::TdivSideW)) u_tdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s2),
		.dividend (ma_s2),
		.divisor  (mb_s2),
		.in_side  (d1_side_in),
		.out_valid(d1_valid),
		.quotient (d1_q),
		.out_side (d1_side)
	);

	logic [31:0] d1_x1;
	logic        d1_neg, d1_zero;
	logic [18:0] d1_up;
	logic [1:0]  d1_oss;
	assign {d1_x1, d1_neg, d1_zero, d1_up, d1_oss} = d1_side;

	// Stages 3 to 8: b5, b6 products, b3, b4 and b7.
	logic        vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic        zero_s3, zero_s4, zero_s5, zero_s6, zero_s7, zero_s8;
	logic [18:0] up_s3, up_s4, up_s5, up_s6, up_s7;
	logic [1:0]  oss_s3, oss_s4, oss_s5, oss_s6, oss_s7;
	logic [31:0] temp_s4, temp_s5, temp_s6, temp_s7, temp_s8;
	logic [31:0] b5_s3, b6sq_s4, ac2b6_s4, ac3b6_s4;
	logic [31:0] sq_s5, x2a_s5, x2a_s6, x1c_s5, x1c_s6;
	logic [31:0] sqb2_s6, b1sq_s6, b3_s7, x3p_s7, b4_s8, b7_s8;
	logic [31:0] b6_c, b3_c, b4p_c, scale_c;

	assign b6_c  = b5_s3 - bpc_pkg::OffsetB6;
	assign b3_c  = bpc_pkg::asr((((ac1 << 2) + bpc_pkg::asr(sqb2_s6, 11) + x2a_s6)
		<< oss_s6) + 32'd2, 2);
	assign b4p_c = ac4 * (x3p_s7 + bpc_pkg::BiasB4);
	assign scale_c = bpc_pkg::ScaleB7 >> oss_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s3 <= d1_valid;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			b5_s3   <= d1_x1 + (d1_neg ? -d1_q : d1_q);
			zero_s3 <= d1_zero;
			up_s3   <= d1_up;
			oss_s3  <= d1_oss;

			temp_s4  <= bpc_pkg::asr(b5_s3 + bpc_pkg::RoundT, 4);
			b6sq_s4  <= b6_c * b6_c;
			ac2b6_s4 <= ac2 * b6_c;
			ac3b6_s4 <= ac3 * b6_c;
			zero_s4  <= zero_s3;
			up_s4    <= up_s3;
			oss_s4   <= oss_s3;

			sq_s5   <= bpc_pkg::asr(b6sq_s4, 12);
			x2a_s5  <= bpc_pkg::asr(ac2b6_s4, 11);
			x1c_s5  <= bpc_pkg::asr(ac3b6_s4, 13);
			temp_s5 <= temp_s4;
			zero_s5 <= zero_s4;
			up_s5   <= up_s4;
			oss_s5  <= oss_s4;

			sqb2_s6 <= sq_s5 * b2;
			b1sq_s6 <= b1 * sq_s5;
			x2a_s6  <= x2a_s5;
			x1c_s6  <= x1c_s5;
			temp_s6 <= temp_s5;
			zero_s6 <= zero_s5;
			up_s6   <= up_s5;
			oss_s6  <= oss_s5;

			b3_s7   <= b3_c;
			x3p_s7  <= bpc_pkg::asr(x1c_s6 + bpc_pkg::asr(b1sq_s6, 16) + 32'd2, 2);
			temp_s7 <= temp_s6;
			zero_s7 <= zero_s6;
			up_s7   <= up_s6;
			oss_s7  <= oss_s6;

			b4_s8   <= b4p_c >> 15;
			b7_s8   <= ({13'd0, up_s7} - b3_s7) * scale_c;
			temp_s8 <= temp_s7;
			zero_s8 <= zero_s7;
		end
	end

	// Pressure division; a large b7 is divided first and doubled afterwards.
	bpc_pkg::tail_ctl_t              ctl_in, ctl_out;
	logic [31:0]                     pdiv_num;
	logic [bpc_pkg::PdivSideW-1:0]   d2_side_in, d2_side;
	logic                            d2_valid;
	logic [31:0]                     d2_q;
	logic [31:0]                     d2_temp;

	always_comb begin
		ctl_in.valid = vld_s8;
		ctl_in.big   = b7_s8[31];
		if (zero_s8) begin
			ctl_in.status = bpc_pkg::ST_TDIV;
		end else if (b4_s8 == '0) begin
			ctl_in.status = bpc_pkg::ST_PDIV;
		end else begin
			ctl_in.status = bpc_pkg::ST_OK;
		end
	end

	assign pdiv_num   = b7_s8[31] ? b7_s8 : {b7_s8[30:0], 1'b0};
	assign d2_side_in = {temp_s8, ctl_in.status, ctl_in.big};

	bpc_div #(.SIDE_W(bpc_pkg::PdivSideW)) u_pdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (ctl_in.valid),
		.dividend (pdiv_num),
		.divisor  (b4_s8),
		.in_side  (d2_side_in),
		.out_valid(d2_valid),
		.quotient (d2_q),
		.out_side (d2_side)
	);

	assign ctl_out.valid  = d2_valid;
	assign ctl_out.status = bpc_pkg::status_t'(d2_side[2:1]);
	assign ctl_out.big    = d2_side[0];
	assign d2_temp        = d2_side[34:3];

	bpc_pkg::status_t res_st;

	bpc_tail u_tail (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.ctl       (ctl_out),
		.quo       (d2_q),
		.temp      (d2_temp),
		.res_valid (res.valid),
		.res_temp  (res.temp_tenths),
		.res_press (res.press_pa),
		.res_status(res_st)
	);

	assign res.status = res_st;

	a_tdiv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.status == bpc_pkg::ST_TDIV |-> res.temp_tenths == '0 && res.press_pa == '0)
		else $error("temperature divisor fault must clear both results");
	a_pdiv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.status == bpc_pkg::ST_PDIV |-> res.press_pa == '0)
		else $error("pressure divisor fault must clear the pressure");
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.status != 2'd3)
		else $error("undefined status code");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		smp.ready == (!res.valid || res.ready))
		else $error("input ready must follow the pipeline enable");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(res.press_pa))
		else $error("held result changed during a stall");
endmodule

// ===== hw/rtl/bpc_div.sv =====
// Pipelined unsigned divider, one quotient bit per stage, with a sideband bus.
// Depends on bpc_pkg for the data width.
module bpc_div #(
	parameter int unsigned SIDE_W = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic [31:0]             dividend,
	input  logic [31:0]             divisor,
	input  logic [SIDE_W-1:0]       in_side,
	output logic                    out_valid,
	output logic [31:0]             quotient,
	output logic [SIDE_W-1:0]       out_side
);
	localparam int unsigned N = bpc_pkg::DataW;

	logic              vld_s [0:N];
	logic [31:0]       rem_s [0:N];
	logic [31:0]       num_s [0:N];
	logic [31:0]       den_s [0:N];
	logic [SIDE_W-1:0] side_s [0:N];

	assign vld_s[0]  = in_valid;
	assign rem_s[0]  = '0;
	assign num_s[0]  = dividend;
	assign den_s[0]  = divisor;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [32:0] trial;
		logic [32:0] diff;
		assign trial = {rem_s[k], num_s[k][31]};
		assign diff  = trial - {1'b0, den_s[k]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
		// The dividend register shifts left and collects quotient bits at the bottom.
		always_ff @(posedge clk) begin
			if (en) begin
				if (!diff[32]) begin
					rem_s[k+1] <= diff[31:0];
				end else begin
					rem_s[k+1] <= trial[31:0];
				end
				num_s[k+1]  <= {num_s[k][30:0], ~diff[32]};
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = vld_s[N];
	assign quotient  = num_s[N];
	assign out_side  = side_s[N];
endmodule

// ===== hw/rtl/bpc_tail.sv =====
// Final pressure correction stages and the result register of the core.
// Depends on bpc_pkg for constants, status codes and the control struct.
module bpc_tail (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  bpc_pkg::tail_ctl_t   ctl,
	input  logic [31:0]          quo,
	input  logic [31:0]          temp,
	output logic                 res_valid,
	output logic [31:0]          res_temp,
	output logic [31:0]          res_press,
	output bpc_pkg::status_t     res_status
);
	logic                vld_s1, vld_s2, vld_s3;
	bpc_pkg::status_t    st_s1, st_s2, st_s3;
	logic [31:0]         temp_s1, temp_s2, temp_s3;
	logic [31:0]         p_s1, p_s2, p_s3;
	logic [31:0]         x1_s1;
	logic [31:0]         x1sq_s2, pmh_s2;
	logic [31:0]         x1mg_s3, x2_s3;
	logic [31:0]         p_new;
	logic [31:0]         press_fin;

	assign p_new     = ctl.big ? {quo[30:0], 1'b0} : quo;
	assign press_fin = p_s3 + bpc_pkg::asr(bpc_pkg::asr(x1mg_s3, 16) + x2_s3
		+ bpc_pkg::ParamMi, 4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			res_valid <= 1'b0;
		end else if (en) begin
			vld_s1    <= ctl.valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			res_valid <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1    <= p_new;
			x1_s1   <= bpc_pkg::asr(p_new, 8);
			st_s1   <= ctl.status;
			temp_s1 <= temp;

			x1sq_s2 <= x1_s1 * x1_s1;
			pmh_s2  <= p_s1 * bpc_pkg::ParamMh;
			p_s2    <= p_s1;
			st_s2   <= st_s1;
			temp_s2 <= temp_s1;

			x1mg_s3 <= x1sq_s2 * bpc_pkg::ParamMg;
			x2_s3   <= bpc_pkg::asr(pmh_s2, 16);
			p_s3    <= p_s2;
			st_s3   <= st_s2;
			temp_s3 <= temp_s2;

			res_status <= st_s3;
			res_temp   <= (st_s3 == bpc_pkg::ST_TDIV) ? '0 : temp_s3;
			res_press  <= (st_s3 == bpc_pkg::ST_OK) ? press_fin : '0;
		end
	end
endmodule
